// ===== hdl/rac_pkg.sv =====
// Shared types, constants and helper functions of the register allocator.
`timescale 1ns / 1ps
package rac_pkg;

    localparam int NUM_REGS  = 32;
    localparam int NUM_VARS  = 16;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int VAR_AW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int OP_W      = 2;
    localparam int VAR_W     = 4;
    localparam int REG_W     = 5;
    localparam int COUNT_W   = 6;
    localparam int NUM_SLOTS = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd63;
    localparam logic [REG_W-1:0]   BASE_RESET = 5'd5;

    localparam logic [1:0] SLOT_BUMP  = 2'd0;
    localparam logic [1:0] SLOT_REL_L = 2'd1;
    localparam logic [1:0] SLOT_REL_R = 2'd2;
    localparam logic [1:0] SLOT_LAST  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ASSIGN_VAR  = 2'd0,
        OP_ASSIGN_TMP  = 2'd1,
        OP_COMBINE_BIN = 2'd2,
        OP_COMBINE_NEG = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [REG_AW-1:0]  rd_addr_a;
        logic [REG_AW-1:0]  rd_addr_b;
        logic               wr_en;
        logic [REG_AW-1:0]  wr_addr;
        logic [COUNT_W-1:0] wr_data;
    } t_cnt_req;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
    } t_slot;

    typedef struct packed {
        logic             found;
        logic [REG_W-1:0] idx;
    } t_free;

    function automatic logic reg_in_range(input logic [REG_W-1:0] r);
        return (int'(r) < NUM_REGS);
    endfunction

    function automatic t_free find_free(input logic [NUM_REGS-1:0] zero_vec,
                                        input logic [REG_W-1:0]    base);
        t_free res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (zero_vec[i] && (i >= int'(base))) begin
                res.found = 1'b1;
                res.idx   = REG_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/rac_in_if.sv =====
// Input channel: one allocator request per transaction.
`timescale 1ns / 1ps
interface rac_in_if;
    logic                       valid;
    logic                       ready;
    logic [rac_pkg::OP_W-1:0]   opcode;
    logic [rac_pkg::VAR_W-1:0]  var_index;
    logic [rac_pkg::REG_W-1:0]  left_reg;
    logic [rac_pkg::REG_W-1:0]  right_reg;

    modport source (output valid, output opcode, output var_index,
                    output left_reg, output right_reg, input ready);
    modport sink   (input valid, input opcode, input var_index,
                    input left_reg, input right_reg, output ready);
endinterface

// ===== hdl/rac_out_if.sv =====
// Output channel: one allocation result per transaction.
`timescale 1ns / 1ps
interface rac_out_if;
    logic                       valid;
    logic                       ready;
    logic [rac_pkg::REG_W-1:0]  dest_reg;
    logic                       out_of_registers;

    modport source (output valid, output dest_reg, output out_of_registers,
                    input ready);
    modport sink   (input valid, input dest_reg, input out_of_registers,
                    output ready);
endinterface

// ===== hdl/rac_count_store.sv =====
// Use-count memory with a flip-flop vector of zero-count registers.
`timescale 1ns / 1ps
module rac_count_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rac_pkg::t_cnt_req                 i_req,
    output logic [rac_pkg::COUNT_W-1:0]       o_count_a,
    output logic [rac_pkg::COUNT_W-1:0]       o_count_b,
    output logic [rac_pkg::NUM_REGS-1:0]      o_zero_vec
);

    logic [rac_pkg::COUNT_W-1:0]  r_mem [rac_pkg::NUM_REGS];
    logic [rac_pkg::COUNT_W-1:0]  r_rd_a;
    logic [rac_pkg::COUNT_W-1:0]  r_rd_b;
    logic                         r_zero_a;
    logic                         r_zero_b;
    logic [rac_pkg::NUM_REGS-1:0] r_zero;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_a   <= r_mem[i_req.rd_addr_a];
        r_rd_b   <= r_mem[i_req.rd_addr_b];
        r_zero_a <= r_zero[i_req.rd_addr_a];
        r_zero_b <= r_zero[i_req.rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= '1;
        end else if (i_req.wr_en) begin
            r_zero[i_req.wr_addr] <= (i_req.wr_data == '0);
        end
    end

    assign o_count_a  = r_zero_a ? '0 : r_rd_a;
    assign o_count_b  = r_zero_b ? '0 : r_rd_b;
    assign o_zero_vec = r_zero;

    a_zero_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |=> (r_zero[$past(i_req.wr_addr)] == ($past(i_req.wr_data) == '0)))
        else $error("zero flag does not follow the written count");

endmodule

// ===== hdl/refcount_register_allocator_core.sv =====
// Top level of the reference-counted register allocator.
// An accepted request is decided, then its count updates are applied before its result
// is offered and the block takes the next request. The use-count memory has a single
// read-modify-write port, through which the bump and up to two releases of one request
// are applied one after another, each in a read state followed by a write state. The lowest
// free register comes from a vector of zero-count flags held in flip-flops. A finished
// result waits in an output register while the next request is accepted.
`timescale 1ns / 1ps
module refcount_register_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rac_in_if.sink                       i_in,
    rac_out_if.source                    o_res,
    input  logic                         i_cfg_we,
    input  logic [rac_pkg::REG_W-1:0]    i_cfg_wdata
);

    rac_pkg::t_state               r_state;
    rac_pkg::t_state               n_state;
    logic [1:0]                    r_step;
    logic [1:0]                    n_step;

    rac_pkg::t_opcode              r_op;
    logic [rac_pkg::VAR_W-1:0]     r_var;
    logic [rac_pkg::REG_W-1:0]     r_left;
    logic [rac_pkg::REG_W-1:0]     r_right;
    logic [rac_pkg::REG_W-1:0]     r_first_alloc;

    logic [rac_pkg::REG_W-1:0]     r_var_map [rac_pkg::NUM_VARS];
    logic [rac_pkg::REG_W-1:0]     r_map_rd;
    logic [rac_pkg::NUM_VARS-1:0]  r_var_mapped;

    rac_pkg::t_slot                r_slot [rac_pkg::NUM_SLOTS];
    rac_pkg::t_slot                w_slot [rac_pkg::NUM_SLOTS];
    logic [rac_pkg::REG_W-1:0]     r_dest;
    logic                          r_fail;
    logic [rac_pkg::REG_W-1:0]     w_dest;
    logic                          w_fail;
    logic                          w_map_we;

    logic                          r_out_valid;
    logic [rac_pkg::REG_W-1:0]     r_out_dest;
    logic                          r_out_fail;

    rac_pkg::t_cnt_req             w_cnt_req;
    logic [rac_pkg::COUNT_W-1:0]   w_count_a;
    logic [rac_pkg::COUNT_W-1:0]   w_count_b;
    logic [rac_pkg::NUM_REGS-1:0]  w_zero_vec;
    logic [rac_pkg::COUNT_W-1:0]   w_new_count;
    logic [rac_pkg::COUNT_W-1:0]   w_cnt_l;
    logic [rac_pkg::COUNT_W-1:0]   w_cnt_r;
    rac_pkg::t_free                w_free;
    logic                          w_var_ok;
    logic                          w_in_ready;
    logic                          w_accept;
    logic                          w_load_out;

    rac_count_store u_count_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_cnt_req),
        .o_count_a  (w_count_a),
        .o_count_b  (w_count_b),
        .o_zero_vec (w_zero_vec)
    );

    assign w_accept = i_in.valid && w_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            rac_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = rac_pkg::S_DECIDE;
                end
            end
            rac_pkg::S_DECIDE: begin
                n_state = rac_pkg::S_RD;
                n_step  = rac_pkg::SLOT_BUMP;
            end
            rac_pkg::S_RD: begin
                if (r_slot[r_step].en) begin
                    n_state = rac_pkg::S_WR;
                end else if (r_step == rac_pkg::SLOT_LAST) begin
                    n_state = rac_pkg::S_DONE;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            rac_pkg::S_WR: begin
                if (r_step == rac_pkg::SLOT_LAST) begin
                    n_state = rac_pkg::S_DONE;
                end else begin
                    n_state = rac_pkg::S_RD;
                    n_step  = r_step + 2'd1;
                end
            end
            rac_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = rac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rac_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        w_in_ready          = (r_state == rac_pkg::S_IDLE);
        w_load_out          = (r_state == rac_pkg::S_DONE) && (!r_out_valid || o_res.ready);
        w_cnt_req.rd_addr_a = (r_state == rac_pkg::S_IDLE) ? i_in.left_reg[rac_pkg::REG_AW-1:0]
                                                           : r_slot[r_step].addr;
        w_cnt_req.rd_addr_b = i_in.right_reg[rac_pkg::REG_AW-1:0];
        w_cnt_req.wr_en     = (r_state == rac_pkg::S_WR);
        w_cnt_req.wr_addr   = r_slot[r_step].addr;
        w_cnt_req.wr_data   = w_new_count;
    end

    always_comb begin
        if (r_step == rac_pkg::SLOT_BUMP) begin
            w_new_count = (w_count_a == rac_pkg::COUNT_MAX) ? w_count_a : w_count_a + 1'b1;
        end else begin
            w_new_count = (w_count_a == '0) ? w_count_a : w_count_a - 1'b1;
        end
    end

    // decide destination and the count updates of the held request
    always_comb begin
        w_cnt_l  = rac_pkg::reg_in_range(r_left)  ? w_count_a : '0;
        w_cnt_r  = rac_pkg::reg_in_range(r_right) ? w_count_b : '0;
        w_free   = rac_pkg::find_free(w_zero_vec, r_first_alloc);
        w_var_ok = (int'(r_var) < rac_pkg::NUM_VARS);
        w_dest   = '0;
        w_fail   = 1'b0;
        w_map_we = 1'b0;
        for (int s = 0; s < rac_pkg::NUM_SLOTS; s++) begin
            w_slot[s] = '0;
        end
        unique case (r_op)
            rac_pkg::OP_ASSIGN_VAR, rac_pkg::OP_ASSIGN_TMP: begin
                priority if ((r_op == rac_pkg::OP_ASSIGN_VAR) && w_var_ok &&
                             r_var_mapped[r_var[rac_pkg::VAR_AW-1:0]]) begin
                    w_dest                          = r_map_rd;
                    w_slot[rac_pkg::SLOT_BUMP].en   = rac_pkg::reg_in_range(r_map_rd);
                    w_slot[rac_pkg::SLOT_BUMP].addr = r_map_rd[rac_pkg::REG_AW-1:0];
                end else if (!w_free.found) begin
                    w_fail = 1'b1;
                end else begin
                    w_dest                          = w_free.idx;
                    w_slot[rac_pkg::SLOT_BUMP].en   = 1'b1;
                    w_slot[rac_pkg::SLOT_BUMP].addr = w_free.idx[rac_pkg::REG_AW-1:0];
                    w_map_we = (r_op == rac_pkg::OP_ASSIGN_VAR) && w_var_ok;
                end
            end
            rac_pkg::OP_COMBINE_BIN: begin
                priority if (w_cnt_l == 6'd1) begin
                    w_dest                           = r_left;
                    w_slot[rac_pkg::SLOT_REL_R].en   = rac_pkg::reg_in_range(r_right);
                    w_slot[rac_pkg::SLOT_REL_R].addr = r_right[rac_pkg::REG_AW-1:0];
                end else if (w_cnt_r == 6'd1) begin
                    w_dest                           = r_right;
                    w_slot[rac_pkg::SLOT_REL_L].en   = rac_pkg::reg_in_range(r_left);
                    w_slot[rac_pkg::SLOT_REL_L].addr = r_left[rac_pkg::REG_AW-1:0];
                end else if (!w_free.found) begin
                    w_fail = 1'b1;
                end else begin
                    w_dest                           = w_free.idx;
                    w_slot[rac_pkg::SLOT_BUMP].en    = 1'b1;
                    w_slot[rac_pkg::SLOT_BUMP].addr  = w_free.idx[rac_pkg::REG_AW-1:0];
                    w_slot[rac_pkg::SLOT_REL_L].en   = rac_pkg::reg_in_range(r_left);
                    w_slot[rac_pkg::SLOT_REL_L].addr = r_left[rac_pkg::REG_AW-1:0];
                    w_slot[rac_pkg::SLOT_REL_R].en   = rac_pkg::reg_in_range(r_right);
                    w_slot[rac_pkg::SLOT_REL_R].addr = r_right[rac_pkg::REG_AW-1:0];
                end
            end
            rac_pkg::OP_COMBINE_NEG: begin
                priority if (w_cnt_l <= 6'd1) begin
                    w_dest = r_left;
                end else if (!w_free.found) begin
                    w_fail = 1'b1;
                end else begin
                    w_dest                           = w_free.idx;
                    w_slot[rac_pkg::SLOT_BUMP].en    = 1'b1;
                    w_slot[rac_pkg::SLOT_BUMP].addr  = w_free.idx[rac_pkg::REG_AW-1:0];
                    w_slot[rac_pkg::SLOT_REL_L].en   = rac_pkg::reg_in_range(r_left);
                    w_slot[rac_pkg::SLOT_REL_L].addr = r_left[rac_pkg::REG_AW-1:0];
                end
            end
            default: begin
                w_fail = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rac_pkg::S_IDLE;
            r_step        <= rac_pkg::SLOT_BUMP;
            r_first_alloc <= rac_pkg::BASE_RESET;
            r_var_mapped  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                r_first_alloc <= i_cfg_wdata;
            end
            if ((r_state == rac_pkg::S_DECIDE) && w_map_we) begin
                r_var_mapped[r_var[rac_pkg::VAR_AW-1:0]] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= rac_pkg::t_opcode'(i_in.opcode);
            r_var   <= i_in.var_index;
            r_left  <= i_in.left_reg;
            r_right <= i_in.right_reg;
        end
        if (r_state == rac_pkg::S_DECIDE) begin
            r_slot <= w_slot;
            r_dest <= w_dest;
            r_fail <= w_fail;
        end
        if (w_load_out) begin
            r_out_dest <= r_dest;
            r_out_fail <= r_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == rac_pkg::S_DECIDE) && w_map_we) begin
            r_var_map[r_var[rac_pkg::VAR_AW-1:0]] <= w_free.idx;
        end
        r_map_rd <= r_var_map[i_in.var_index[rac_pkg::VAR_AW-1:0]];
    end

    assign i_in.ready             = w_in_ready;
    assign o_res.valid            = r_out_valid;
    assign o_res.dest_reg         = r_out_dest;
    assign o_res.out_of_registers = r_out_fail;

    a_fail_zero_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.out_of_registers) |-> (o_res.dest_reg == '0))
        else $error("failed allocation carries a nonzero destination");

    a_fail_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rac_pkg::S_DECIDE) && w_fail) |->
            !(w_slot[rac_pkg::SLOT_BUMP].en || w_slot[rac_pkg::SLOT_REL_L].en ||
              w_slot[rac_pkg::SLOT_REL_R].en || w_map_we))
        else $error("failed allocation would change state");

    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == rac_pkg::S_DECIDE))
        else $error("accepted transaction not taken to decision");

endmodule

// ===== tb/sv/alloc_result_checker.sv =====
// Checker: tracks register use counts and variable bindings, predicts and compares results.
`timescale 1ns / 1ps
module alloc_result_checker
    import rac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    rac_in_if                i_req,
    rac_out_if               i_res,
    input  logic             i_cfg_we,
    input  logic [REG_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_oor_seen
);

    typedef struct packed {
        logic [REG_W-1:0] dest;
        logic             oor;
    } t_alloc_res;

    t_alloc_res         expected_q[$];
    logic [COUNT_W-1:0] use_cnt   [NUM_REGS];
    logic [REG_W-1:0]   var_map   [NUM_VARS];
    logic               var_bound [NUM_VARS];
    logic [REG_W-1:0]   alloc_base;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_oor_seen   = 0;
    end

    task automatic bump(input logic [REG_W-1:0] r);
        if (use_cnt[r] != COUNT_MAX) use_cnt[r] = use_cnt[r] + 1'b1;
    endtask

    task automatic drop(input logic [REG_W-1:0] r);
        if (use_cnt[r] != '0) use_cnt[r] = use_cnt[r] - 1'b1;
    endtask

    function automatic int lowest_free_reg();
        for (int i = int'(alloc_base); i < NUM_REGS; i++) begin
            if (use_cnt[i] == '0) return i;
        end
        return NUM_REGS;
    endfunction

    task automatic predict_alloc(input t_opcode op, input logic [VAR_W-1:0] v,
                                 input logic [REG_W-1:0] l, input logic [REG_W-1:0] r,
                                 output t_alloc_res res);
        int fr;
        res = '0;
        fr  = lowest_free_reg();
        case (op)
            OP_ASSIGN_VAR, OP_ASSIGN_TMP: begin
                if (op == OP_ASSIGN_VAR && var_bound[v]) begin
                    res.dest = var_map[v];
                    bump(var_map[v]);
                end else if (fr >= NUM_REGS) begin
                    res.oor = 1'b1;
                end else begin
                    res.dest = REG_W'(fr);
                    bump(res.dest);
                    if (op == OP_ASSIGN_VAR) begin
                        var_map[v]   = REG_W'(fr);
                        var_bound[v] = 1'b1;
                    end
                end
            end
            OP_COMBINE_BIN: begin
                if (use_cnt[l] == COUNT_W'(1)) begin
                    res.dest = l;
                    drop(r);
                end else if (use_cnt[r] == COUNT_W'(1)) begin
                    res.dest = r;
                    drop(l);
                end else if (fr >= NUM_REGS) begin
                    res.oor = 1'b1;
                end else begin
                    res.dest = REG_W'(fr);
                    bump(res.dest);
                    drop(l);
                    drop(r);
                end
            end
            default: begin
                if (use_cnt[l] <= COUNT_W'(1)) begin
                    res.dest = l;
                end else if (fr >= NUM_REGS) begin
                    res.oor = 1'b1;
                end else begin
                    res.dest = REG_W'(fr);
                    bump(res.dest);
                    drop(l);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_alloc_res want;
        t_alloc_res got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) use_cnt[i] = '0;
            for (int i = 0; i < NUM_VARS; i++) begin
                var_map[i]   = '0;
                var_bound[i] = 1'b0;
            end
            alloc_base = BASE_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_we) alloc_base = i_cfg_wdata;
            if (i_res.valid && i_res.ready) begin
                got.dest = i_res.dest_reg;
                got.oor  = i_res.out_of_registers;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result dest_reg %0d out_of_registers %0b",
                             $time, got.dest, got.oor);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.dest !== want.dest) begin
                        $display("%0t: dest_reg mismatch, expected %0d actual %0d",
                                 $time, want.dest, got.dest);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.oor !== want.oor) begin
                        $display("%0t: out_of_registers mismatch, expected %0b actual %0b",
                                 $time, want.oor, got.oor);
                        o_fail_count = o_fail_count + 1;
                    end
                    o_checked = o_checked + 1;
                    if (want.oor) o_oor_seen = o_oor_seen + 1;
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_alloc(t_opcode'(i_req.opcode), i_req.var_index,
                              i_req.left_reg, i_req.right_reg, want);
                expected_q.push_back(want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/sv/refcount_register_allocator_core_tb.sv =====
// Testbench top: drives requests and base settings into the allocator and reports the verdict.
`timescale 1ns / 1ps
module refcount_register_allocator_core_tb;
    import rac_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int SAT_BURST    = 70;
    localparam int PHASE_ITEMS  = 150;
    localparam int IDLE_PERCENT = 15;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [REG_W-1:0] cfg_wdata;
    logic [REG_W-1:0] base_now;
    bit               calm;
    int               fail_count;
    int               pending;
    int               checked;
    int               oor_seen;
    int               sent;
    int               settings_used;
    int               idle_cycles;

    rac_in_if  req_ch();
    rac_out_if res_ch();

    refcount_register_allocator_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    alloc_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_oor_seen   (oor_seen)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk) begin
        res_ch.ready <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_opcode op, input logic [VAR_W-1:0] v,
                             input logic [REG_W-1:0] l, input logic [REG_W-1:0] r);
        while (!calm && $urandom_range(99, 0) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.var_index <= v;
        req_ch.left_reg  <= l;
        req_ch.right_reg <= r;
        do @(posedge clk); while (!req_ch.ready);
        sent = sent + 1;
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_base(input logic [REG_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        base_now  = value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    function automatic logic [REG_W-1:0] pick_src();
        int lo;
        int hi;
        lo = int'(base_now);
        hi = (lo + 7 > NUM_REGS - 1) ? NUM_REGS - 1 : lo + 7;
        if ($urandom_range(99, 0) < 75) return REG_W'($urandom_range(hi, lo));
        return REG_W'($urandom_range(NUM_REGS - 1, 0));
    endfunction

    task automatic run_phase(input int n_items);
        int               done;
        logic [VAR_W-1:0] v;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(99, 0) < 4) begin
                v = VAR_W'($urandom_range(NUM_VARS - 1, 0));
                repeat (SAT_BURST) send_item(OP_ASSIGN_VAR, v, pick_src(), pick_src());
                done = done + SAT_BURST;
            end else begin
                send_item(t_opcode'($urandom_range(3, 0)),
                          VAR_W'($urandom_range(NUM_VARS - 1, 0)), pick_src(), pick_src());
                done = done + 1;
            end
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        base_now         = BASE_RESET;
        calm             = 1'b0;
        sent             = 0;
        settings_used    = 1;
        idle_cycles      = 0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_ASSIGN_VAR;
        req_ch.var_index = '0;
        req_ch.left_reg  = '0;
        req_ch.right_reg = '0;
        res_ch.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(OP_ASSIGN_VAR,  4'd0,  5'd0,  5'd31);
        send_item(OP_ASSIGN_VAR,  4'd0,  5'd31, 5'd0);
        send_item(OP_ASSIGN_VAR,  4'd15, 5'd0,  5'd0);
        send_item(OP_ASSIGN_TMP,  4'd15, 5'd31, 5'd31);
        send_item(OP_COMBINE_BIN, 4'd0,  5'd6,  5'd7);
        send_item(OP_ASSIGN_TMP,  4'd0,  5'd0,  5'd0);
        send_item(OP_COMBINE_BIN, 4'd0,  5'd5,  5'd7);
        send_item(OP_ASSIGN_VAR,  4'd0,  5'd0,  5'd0);
        send_item(OP_COMBINE_BIN, 4'd0,  5'd5,  5'd5);
        send_item(OP_COMBINE_BIN, 4'd0,  5'd0,  5'd31);
        send_item(OP_COMBINE_NEG, 4'd0,  5'd31, 5'd0);
        send_item(OP_COMBINE_NEG, 4'd0,  5'd9,  5'd0);
        send_item(OP_ASSIGN_VAR,  4'd15, 5'd0,  5'd0);
        send_item(OP_COMBINE_NEG, 4'd0,  5'd6,  5'd31);

        write_base(5'd31);
        send_item(OP_ASSIGN_TMP,  4'd0,  5'd0,  5'd0);
        send_item(OP_ASSIGN_TMP,  4'd0,  5'd0,  5'd0);
        send_item(OP_ASSIGN_VAR,  4'd3,  5'd0,  5'd0);
        send_item(OP_ASSIGN_VAR,  4'd0,  5'd0,  5'd0);
        send_item(OP_COMBINE_NEG, 4'd0,  5'd5,  5'd0);
        send_item(OP_COMBINE_BIN, 4'd0,  5'd5,  5'd5);

        write_base(5'd0);
        send_item(OP_ASSIGN_TMP,  4'd0,  5'd0,  5'd0);
        send_item(OP_ASSIGN_VAR,  4'd3,  5'd0,  5'd0);
        send_item(OP_COMBINE_NEG, 4'd0,  5'd0,  5'd0);

        write_base(5'd1);
        run_phase(PHASE_ITEMS);
        write_base(5'd31);
        run_phase(PHASE_ITEMS);
        write_base(REG_W'($urandom_range(NUM_REGS - 1, 1)));
        calm = 1'b1;
        run_phase(PHASE_ITEMS);
        calm = 1'b0;
        write_base(5'd0);
        run_phase(PHASE_ITEMS);
        write_base(BASE_RESET);
        run_phase(PHASE_ITEMS);
        write_base(REG_W'($urandom_range(NUM_REGS - 1, 1)));
        run_phase(PHASE_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Run covered %0d requests under %0d base register settings.",
                 sent, settings_used);
        $display("%0d results compared, %0d of them reported out of registers.",
                 checked, oor_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
